// ===== hw/rtl/ocrc_pkg.sv =====
// ocrc_pkg: shared types, constants and helpers for the column range clipper.
// No dependencies; imported by the top level, both checkers and tb_top.
`timescale 1ns / 1ps

package ocrc_pkg;

    localparam int MAX_RANGES  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(MAX_RANGES);
    localparam int CNT_W       = $clog2(MAX_RANGES + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int COL_W       = 11;
    localparam int VW_W        = 12;
    localparam int OP_W        = 2;
    localparam int ENT_W       = 16;
    localparam int WIDE_W      = ENT_W + 1;

    localparam logic [VW_W-1:0] RESET_VIEW_WIDTH = 12'd320;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_SOLID = 2'd1;
    localparam logic [OP_W-1:0] OP_PASS  = 2'd2;

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t EDGE_LOW  = -17'sd32767;
    localparam wide_t EDGE_HIGH = 17'sd32767;
    localparam wide_t NEG_ONE   = -17'sd1;
    localparam wide_t WIDE_ONE  = 17'sd1;

    typedef struct packed {
        logic signed [ENT_W-1:0] lo;
        logic signed [ENT_W-1:0] hi;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR0,
        ST_CLR1,
        ST_FETCH,
        ST_SEEK,
        ST_SHIFT,
        ST_MERGE,
        ST_PACK,
        ST_FINISH
    } state_t;

    function automatic wide_t widen(input logic signed [ENT_W-1:0] x);
        widen = $signed({x[ENT_W-1], x});
    endfunction

    function automatic entry_t make_entry(input wide_t lo, input wide_t hi);
        entry_t e;
        e.lo = lo[ENT_W-1:0];
        e.hi = hi[ENT_W-1:0];
        make_entry = e;
    endfunction

endpackage

// ===== hw/rtl/ocrc_ram.sv =====
// ocrc_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No package dependency.
`timescale 1ns / 1ps

module ocrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/occluded_column_range_clipper.sv =====
// occluded_column_range_clipper: top level, sequencer and result staging.
// Depends on ocrc_pkg and ocrc_ram (range list storage).
//
// Keeps a sorted list of covered column ranges in a 32-entry RAM and walks it
// one entry per clock unless an output stall holds it. One item is in work at a
// time; in_ready is high only while idle. A clear writes the two sentinel ranges.
// A clip walks the list from its start and also moves entries when a solid clip
// inserts a range or folds several ranges together; the single RAM read port
// makes every step one entry. Fragments leave through a one-deep output register
// and stall the walk while it is held. After reset the block writes the sentinel
// ranges before it is ready. view_width takes effect at the next clear.
`timescale 1ns / 1ps

module occluded_column_range_clipper (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ocrc_pkg::VW_W-1:0]  view_width,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ocrc_pkg::OP_W-1:0]  opcode,
    input  logic [ocrc_pkg::COL_W-1:0] first_col,
    input  logic [ocrc_pkg::COL_W-1:0] last_col,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ocrc_pkg::COL_W-1:0] frag_first,
    output logic [ocrc_pkg::COL_W-1:0] frag_last,
    output logic                       frag_valid,
    output logic                       last_of_run,
    output logic                       overflow
);

    import ocrc_pkg::*;

    state_t             state_reg, state_next;
    logic [VW_W-1:0]    vw_reg;
    logic               init_reg;
    logic               solid_reg;
    wide_t              f_reg, l_reg;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   s_reg, s_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    wide_t              glo_reg, glo_next;
    wide_t              ghi_reg, ghi_next;
    entry_t             hold_reg, hold_next;
    logic [RES_W-1:0]   fcnt_reg;

    logic               pend_valid_reg;
    logic [COL_W-1:0]   pend_first_reg, pend_last_reg;
    logic               pend_ovf_reg;

    logic               out_valid_reg;
    logic [COL_W-1:0]   out_first_reg, out_last_reg;
    logic               out_fvalid_reg, out_lor_reg, out_ovf_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    entry_t             ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             e;
    wide_t              e_lo, e_hi, e_lo_m1, f_m1, ghi_p1, glo_sel;
    logic [VW_W-1:0]    clr_width;

    logic               in_fire, cfg_fire, clip_ok;
    logic               k_more, k_in, list_full, seek_more;
    logic               at_left, l_left_gap, l_covered, m_gap, shift_last, merge_pack;
    logic [CNT_W-1:0]   k_inc;
    logic               advance;

    logic               emit_req, emit_ok, emit_ovf, emit_fire, stall;
    wide_t              emit_a, emit_b;
    logic               out_free, fin_fire;

    ocrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_ocrc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign e        = entry_t'(ram_rdata);
    assign e_lo     = widen(e.lo);
    assign e_hi     = widen(e.hi);
    assign e_lo_m1  = e_lo - WIDE_ONE;
    assign f_m1     = f_reg - WIDE_ONE;
    assign ghi_p1   = ghi_reg + WIDE_ONE;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign clip_ok   = ((opcode == OP_SOLID) || (opcode == OP_PASS)) && (last_col >= first_col);
    assign clr_width = init_reg ? RESET_VIEW_WIDTH : vw_reg;

    assign k_inc      = k_reg + 1'b1;
    assign k_more     = ({1'b0, k_reg} + 1'b1) < {1'b0, cnt_reg};
    assign k_in       = k_reg < cnt_reg;
    assign list_full  = cnt_reg >= CNT_W'(MAX_RANGES);
    assign seek_more  = k_more && (e_hi < f_m1);
    assign at_left    = f_reg < e_lo;
    assign l_left_gap = l_reg < e_lo_m1;
    assign l_covered  = l_reg <= e_hi;
    assign m_gap      = k_in && (l_reg >= e_lo_m1);
    assign shift_last = k_reg == (cnt_reg - 1'b1);
    assign merge_pack = k_reg != (s_reg + 1'b1);
    assign glo_sel    = (at_left && solid_reg) ? f_reg : e_lo;

    // fragment request for this step
    always_comb
    begin
        emit_req = 1'b0;
        emit_a   = f_reg;
        emit_b   = l_reg;
        emit_ovf = 1'b0;
        case (state_reg)
            ST_SEEK:
            begin
                if (!seek_more)
                begin
                    if (at_left && l_left_gap)
                    begin
                        emit_req = 1'b1;
                        emit_ovf = solid_reg && list_full;
                    end
                    else if (at_left)
                    begin
                        emit_req = 1'b1;
                        emit_b   = e_lo_m1;
                    end
                end
            end
            ST_MERGE:
            begin
                emit_req = 1'b1;
                emit_a   = ghi_p1;
                emit_b   = m_gap ? e_lo_m1 : l_reg;
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_ok   = emit_req && (emit_a <= emit_b) && (fcnt_reg < RES_W'(MAX_RESULTS));
    assign stall     = emit_ok && pend_valid_reg && !out_free;
    assign emit_fire = emit_ok && !stall;
    assign fin_fire  = (state_reg == ST_FINISH) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OP_CLEAR)
                    begin
                        state_next = ST_CLR0;
                    end
                    else if (clip_ok)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CLR0:
            begin
                state_next = ST_CLR1;
            end
            ST_CLR1:
            begin
                state_next = init_reg ? ST_IDLE : ST_FINISH;
            end
            ST_FETCH:
            begin
                state_next = ST_SEEK;
            end
            ST_SEEK:
            begin
                if (!stall && !seek_more)
                begin
                    if (at_left && l_left_gap)
                    begin
                        state_next = (solid_reg && !list_full) ? ST_SHIFT : ST_FINISH;
                    end
                    else if (l_covered)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MERGE:
            begin
                if (!stall)
                begin
                    if (m_gap)
                    begin
                        if (l_covered)
                        begin
                            state_next = solid_reg ? ST_PACK : ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = (solid_reg && merge_pack) ? ST_PACK : ST_FINISH;
                    end
                end
            end
            ST_PACK:
            begin
                if (!k_in)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // list walk and RAM control
    always_comb
    begin
        advance   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = k_reg[IDX_W-1:0];
        ram_wdata = hold_reg;
        ram_raddr = k_reg[IDX_W-1:0];
        k_next    = k_reg;
        s_next    = s_reg;
        w_next    = w_reg;
        cnt_next  = cnt_reg;
        glo_next  = glo_reg;
        ghi_next  = ghi_reg;
        hold_next = hold_reg;
        case (state_reg)
            ST_CLR0:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(0);
                ram_wdata = make_entry(EDGE_LOW, NEG_ONE);
            end
            ST_CLR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(1);
                ram_wdata = make_entry($signed({{(WIDE_W-VW_W){1'b0}}, clr_width}), EDGE_HIGH);
                cnt_next  = CNT_W'(2);
            end
            ST_FETCH:
            begin
                ram_raddr = '0;
                k_next    = '0;
            end
            ST_SEEK:
            begin
                if (!stall)
                begin
                    if (seek_more)
                    begin
                        advance = 1'b1;
                    end
                    else if (at_left && l_left_gap)
                    begin
                        if (solid_reg && !list_full)
                        begin
                            // new range goes in at k, the rest moves up one
                            ram_we    = 1'b1;
                            ram_wdata = make_entry(f_reg, l_reg);
                            hold_next = e;
                            cnt_next  = cnt_reg + 1'b1;
                            advance   = 1'b1;
                        end
                    end
                    else
                    begin
                        glo_next = glo_sel;
                        if (l_covered)
                        begin
                            ram_we    = solid_reg;
                            ram_wdata = make_entry(glo_sel, e_hi);
                        end
                        else
                        begin
                            s_next   = k_reg;
                            ghi_next = e_hi;
                            advance  = 1'b1;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                ram_we = 1'b1;
                if (!shift_last)
                begin
                    hold_next = e;
                    advance   = 1'b1;
                end
            end
            ST_MERGE:
            begin
                if (!stall)
                begin
                    ram_waddr = s_reg[IDX_W-1:0];
                    if (m_gap)
                    begin
                        ghi_next = e_hi;
                        advance  = 1'b1;
                        if (l_covered)
                        begin
                            ram_we    = solid_reg;
                            ram_wdata = make_entry(glo_reg, e_hi);
                            w_next    = s_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ram_we    = solid_reg;
                        ram_wdata = make_entry(glo_reg, l_reg);
                        w_next    = s_reg + 1'b1;
                    end
                end
            end
            ST_PACK:
            begin
                if (k_in)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[IDX_W-1:0];
                    ram_wdata = e;
                    w_next    = w_reg + 1'b1;
                    advance   = 1'b1;
                end
                else
                begin
                    cnt_next = w_reg;
                end
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase
        if (advance)
        begin
            k_next    = k_inc;
            ram_raddr = k_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR0;
            init_reg       <= 1'b1;
            vw_reg         <= RESET_VIEW_WIDTH;
            cnt_reg        <= CNT_W'(2);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_CLR1)
            begin
                init_reg <= 1'b0;
            end
            if (cfg_fire)
            begin
                vw_reg <= view_width;
            end
            if (emit_fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (fin_fire)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((emit_fire && pend_valid_reg) || fin_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        s_reg    <= s_next;
        w_reg    <= w_next;
        glo_reg  <= glo_next;
        ghi_reg  <= ghi_next;
        hold_reg <= hold_next;
        if (in_fire)
        begin
            f_reg     <= $signed({{(WIDE_W-COL_W){1'b0}}, first_col});
            l_reg     <= $signed({{(WIDE_W-COL_W){1'b0}}, last_col});
            solid_reg <= (opcode == OP_SOLID);
            fcnt_reg  <= '0;
        end
        else if (emit_fire)
        begin
            fcnt_reg <= fcnt_reg + 1'b1;
        end
        // one fragment of lookahead so the final one can carry last_of_run
        if (emit_fire)
        begin
            pend_first_reg <= emit_a[COL_W-1:0];
            pend_last_reg  <= emit_b[COL_W-1:0];
            pend_ovf_reg   <= emit_ovf;
        end
        if (emit_fire && pend_valid_reg)
        begin
            out_first_reg  <= pend_first_reg;
            out_last_reg   <= pend_last_reg;
            out_fvalid_reg <= 1'b1;
            out_lor_reg    <= 1'b0;
            out_ovf_reg    <= pend_ovf_reg;
        end
        else if (fin_fire)
        begin
            out_first_reg  <= pend_valid_reg ? pend_first_reg : '0;
            out_last_reg   <= pend_valid_reg ? pend_last_reg : '0;
            out_fvalid_reg <= pend_valid_reg;
            out_lor_reg    <= 1'b1;
            out_ovf_reg    <= pend_valid_reg && pend_ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frag_first  = out_first_reg;
    assign frag_last   = out_last_reg;
    assign frag_valid  = out_fvalid_reg;
    assign last_of_run = out_lor_reg;
    assign overflow    = out_ovf_reg;

endmodule

// ===== hw/rtl/ocrc_checker.sv =====
// ocrc_checker: port-level assertions for the column range clipper, and the
// bind that attaches them to occluded_column_range_clipper. Uses ocrc_pkg.
`timescale 1ns / 1ps

module ocrc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ocrc_pkg::COL_W-1:0] frag_first,
    input logic [ocrc_pkg::COL_W-1:0] frag_last,
    input logic                       frag_valid,
    input logic                       last_of_run,
    input logic                       overflow
);

    import ocrc_pkg::*;

    // held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frag_first)
            && $stable(frag_last) && $stable(frag_valid)
            && $stable(last_of_run) && $stable(overflow))
        else $error("result changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // an empty acknowledgement always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frag_valid |-> last_of_run && !overflow)
        else $error("empty acknowledgement not final");

    // a refused insert is a valid fragment and the last of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> frag_valid && last_of_run)
        else $error("overflow result malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frag_valid |-> frag_first <= frag_last)
        else $error("fragment reversed");

endmodule

bind occluded_column_range_clipper ocrc_checker u_ocrc_checker (.*);

// ===== verif/ocrc_frag_checker.sv =====
// ocrc_frag_checker: predicts the fragments of the column range clipper and compares them
// with every output transfer. Depends on ocrc_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module ocrc_frag_checker
    import ocrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [VW_W-1:0]  view_width,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [OP_W-1:0]  opcode,
    input  logic [COL_W-1:0] first_col,
    input  logic [COL_W-1:0] last_col,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [COL_W-1:0] frag_first,
    input  logic [COL_W-1:0] frag_last,
    input  logic             frag_valid,
    input  logic             last_of_run,
    input  logic             overflow,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic [COL_W-1:0] first_c;
        logic [COL_W-1:0] last_c;
        logic             valid;
        logic             tail;
        logic             ovf;
    } frag_t;

    frag_t           due_frags[$];
    frag_t           held_frag;
    bit              have_held;
    int              run_n;

    int              lo_q[MAX_RANGES];
    int              hi_q[MAX_RANGES];
    int              range_cnt;
    logic [VW_W-1:0] vw_q = RESET_VIEW_WIDTH;

    function automatic void emit_frag(input int a, input int b, input bit ovf);
        if (a > b || run_n >= MAX_RESULTS)
            return;
        if (have_held)
            due_frags.push_back(held_frag);
        held_frag.first_c = a[COL_W-1:0];
        held_frag.last_c  = b[COL_W-1:0];
        held_frag.valid   = 1'b1;
        held_frag.tail    = 1'b0;
        held_frag.ovf     = ovf;
        have_held = 1'b1;
        run_n++;
    endfunction

    function automatic void clear_ranges();
        lo_q[0]   = EDGE_LOW;
        hi_q[0]   = NEG_ONE;
        lo_q[1]   = int'(vw_q);
        hi_q[1]   = EDGE_HIGH;
        range_cnt = 2;
    endfunction

    function automatic void clip_span(input int f, input int l, input bit solid);
        int s;
        int nx;
        int i;
        bit closed;
        s = 0;
        closed = 1'b0;
        while (s + 1 < range_cnt && hi_q[s] < f - 1)
            s++;
        if (f < lo_q[s])
        begin
            if (l < lo_q[s] - 1)
            begin
                if (!solid)
                    emit_frag(f, l, 1'b0);
                else if (range_cnt >= MAX_RANGES)
                    emit_frag(f, l, 1'b1);
                else
                begin
                    emit_frag(f, l, 1'b0);
                    for (i = range_cnt; i > s; i--)
                    begin
                        lo_q[i] = lo_q[i-1];
                        hi_q[i] = hi_q[i-1];
                    end
                    lo_q[s] = f;
                    hi_q[s] = l;
                    range_cnt++;
                end
                return;
            end
            emit_frag(f, lo_q[s] - 1, 1'b0);
            if (solid)
                lo_q[s] = f;
        end
        if (l <= hi_q[s])
            return;
        nx = s;
        while (nx + 1 < range_cnt && l >= lo_q[nx+1] - 1)
        begin
            emit_frag(hi_q[nx] + 1, lo_q[nx+1] - 1, 1'b0);
            nx++;
            if (l <= hi_q[nx])
            begin
                if (solid)
                    hi_q[s] = hi_q[nx];
                closed = 1'b1;
                break;
            end
        end
        if (!closed)
        begin
            emit_frag(hi_q[nx] + 1, l, 1'b0);
            if (solid)
                hi_q[s] = l;
        end
        // fold the swallowed ranges out of the list
        if (solid && nx != s)
        begin
            for (i = s + 1; i + (nx - s) < range_cnt; i++)
            begin
                lo_q[i] = lo_q[i + (nx - s)];
                hi_q[i] = hi_q[i + (nx - s)];
            end
            range_cnt -= nx - s;
        end
    endfunction

    function automatic void predict_frags(input logic [OP_W-1:0] op,
                                          input logic [COL_W-1:0] f,
                                          input logic [COL_W-1:0] l);
        run_n = 0;
        have_held = 1'b0;
        if (op == OP_CLEAR)
            clear_ranges();
        else if ((op == OP_SOLID || op == OP_PASS) && l >= f)
            clip_span(int'(f), int'(l), op == OP_SOLID);
        if (!have_held)
            held_frag = '0;
        held_frag.tail = 1'b1;
        due_frags.push_back(held_frag);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frag_t got;
        frag_t want;
        if (!rst_n)
        begin
            vw_q = RESET_VIEW_WIDTH;
            clear_ranges();
            due_frags.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vw_q = view_width;
            if (in_valid && in_ready)
                predict_frags(opcode, first_col, last_col);
            if (out_valid && out_ready)
            begin
                got = '{frag_first, frag_last, frag_valid, last_of_run, overflow};
                if (due_frags.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer: first=%0d last=%0d valid=%0b tail=%0b ovf=%0b",
                             $time, got.first_c, got.last_c, got.valid, got.tail, got.ovf);
                end
                else
                begin
                    want = due_frags.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected first=%0d last=%0d valid=%0b tail=%0b ovf=%0b",
                                 $time, want.first_c, want.last_c, want.valid, want.tail,
                                 want.ovf);
                        $display("%0t:           actual   first=%0d last=%0d valid=%0b tail=%0b ovf=%0b",
                                 $time, got.first_c, got.last_c, got.valid, got.tail, got.ovf);
                    end
                end
            end
            pending = due_frags.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: stimulus and verdict for occluded_column_range_clipper.
// Depends on ocrc_pkg, the block and ocrc_frag_checker, which does all prediction.
`timescale 1ns / 1ps

module tb_top;
    import ocrc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              DRAIN_CYCLES = 40;
    localparam int              NUM_PHASES   = 9;
    localparam int              PHASE_ITEMS  = 11;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [VW_W-1:0]  view_width;
    logic             in_valid;
    logic             in_ready;
    logic [OP_W-1:0]  opcode;
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] last_col;
    logic             out_valid;
    logic             out_ready;
    logic [COL_W-1:0] frag_first;
    logic [COL_W-1:0] frag_last;
    logic             frag_valid;
    logic             last_of_run;
    logic             overflow;
    int               errors;
    int               pending;
    bit               no_gaps = 1'b0;

    occluded_column_range_clipper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .view_width  (view_width),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .first_col   (first_col),
        .last_col    (last_col),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frag_first  (frag_first),
        .frag_last   (frag_last),
        .frag_valid  (frag_valid),
        .last_of_run (last_of_run),
        .overflow    (overflow)
    );

    ocrc_frag_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .view_width  (view_width),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .first_col   (first_col),
        .last_col    (last_col),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frag_first  (frag_first),
        .frag_last   (frag_last),
        .frag_valid  (frag_valid),
        .last_of_run (last_of_run),
        .overflow    (overflow),
        .errors      (errors),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input int f, input int l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        first_col <= f[COL_W-1:0];
        last_col  <= l[COL_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // waits until every fragment has been seen, then lets the block settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_view_width(input logic [VW_W-1:0] vw);
        wait_drain();
        cfg_valid  <= 1'b1;
        view_width <= vw;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input logic [VW_W-1:0] vw);
        int r;
        int lim;
        int f;
        int l;
        int w;
        logic [OP_W-1:0] op;
        lim = (vw == 0) ? 15 : ((vw > 2047) ? 2047 : int'(vw));
        op = ($urandom_range(0, 1) == 1) ? OP_SOLID : OP_PASS;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 3);
            f = $urandom_range(0, lim);
            l = (f + w > 2047) ? 2047 : f + w;
            send_item(OP_SOLID, f, l);
        end
        else if (r < 80)
        begin
            f = $urandom_range(0, lim);
            l = $urandom_range(f, (f + 200 > 2047) ? 2047 : f + 200);
            send_item(OP_PASS, f, l);
        end
        else if (r < 86)
        begin
            f = $urandom_range(0, 2047);
            l = $urandom_range(f, 2047);
            send_item(op, f, l);
        end
        else if (r < 92)
        begin
            f = $urandom_range(1, 2047);
            l = $urandom_range(0, f - 1);
            send_item(op, f, l);
        end
        else if (r < 96)
            send_item(OP_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047));
        else
            send_item(OP_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
    endtask

    initial
    begin : rx_side
        int run_len;
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : tx_side
        logic [VW_W-1:0] phase_vw[NUM_PHASES];
        logic [VW_W-1:0] vw;
        int c;
        cfg_valid  <= 1'b0;
        view_width <= RESET_VIEW_WIDTH;
        in_valid   <= 1'b0;
        opcode     <= OP_CLEAR;
        first_col  <= '0;
        last_col   <= '0;
        phase_vw = '{12'd320, 12'd1, 12'd2048, 12'd4095, 12'd0, 12'd64,
                     12'($urandom_range(1, 4095)), 12'($urandom_range(96, 700)),
                     12'($urandom_range(1, 4095))};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset view width
        send_item(OP_PASS, 0, 2047);
        send_item(OP_SOLID, 10, 20);
        send_item(OP_SOLID, 5, 9);
        send_item(OP_SOLID, 21, 30);
        send_item(OP_PASS, 0, 100);
        send_item(OP_SOLID, 50, 60);
        send_item(OP_SOLID, 70, 80);
        send_item(OP_SOLID, 40, 90);
        send_item(OP_SOLID, 100, 50);
        send_item(OP_PASS, 2047, 0);
        send_item(OP_UNUSED, 2047, 0);
        send_item(OP_PASS, 2047, 2047);
        send_item(OP_SOLID, 0, 0);
        send_item(OP_SOLID, 0, 2047);
        send_item(OP_PASS, 0, 2047);
        send_item(OP_CLEAR, 2047, 2047);
        send_item(OP_PASS, 0, 0);
        send_item(OP_SOLID, 319, 319);
        send_item(OP_SOLID, 0, 318);
        send_item(OP_PASS, 0, 2047);
        send_item(OP_CLEAR, 0, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            vw = phase_vw[p];
            no_gaps = (p == 3);
            write_view_width(vw);
            send_item(OP_CLEAR, 0, 0);
            // fill the list with isolated columns so later inserts hit the full list
            if (vw >= 96 && (p == 0 || p == 2 || p == 7))
            begin
                for (int k = 0; k < 30; k++)
                begin
                    c = 3 * k + $urandom_range(0, 1);
                    send_item(OP_SOLID, c, c);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(vw);
        end

        no_gaps = 1'b0;
        wait_drain();
        if (errors == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ocrc_pkg.sv
hw/rtl/ocrc_ram.sv
hw/rtl/occluded_column_range_clipper.sv
hw/rtl/ocrc_checker.sv
verif/ocrc_frag_checker.sv
verif/tb_top.sv
